>>> rtl/core/glq_pkg.sv
// -----------------------------------------------------------------------------
// glq_pkg
// Shared types, constants and helpers for the glyph quad layout block.
// -----------------------------------------------------------------------------
package glq_pkg;

   localparam int GLYPH_COUNT_DEF = 95;

   localparam logic [7:0]  FIRST_CODE    = 8'd33;
   localparam logic [7:0]  LAST_CODE     = 8'd127;
   localparam logic [7:0]  CODE_LF       = 8'd10;
   localparam logic [7:0]  CODE_CR       = 8'd13;
   localparam logic [7:0]  CODE_SPACE    = 8'd32;
   localparam logic [7:0]  CODE_Y_SLOT   = 8'd88;   // 'y' minus first code
   localparam logic [15:0] SPACE_ADVANCE = 16'd5;
   localparam logic [15:0] LINE_GAP      = 16'd2;
   localparam logic [23:0] FULL_WHITE    = 24'hffffff;

   localparam logic [23:0] PLAIN_COLOUR_RST = 24'hffffff;
   localparam logic [11:0] FADE_TOP_RST     = 12'd280;
   localparam logic [11:0] FADE_BOTTOM_RST  = 12'd430;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_CHAR  = 2'd1,
      OP_LOAD  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_FADE_ENABLE  = 2'd0,
      CSR_PLAIN_COLOUR = 2'd1,
      CSR_FADE_TOP     = 2'd2,
      CSR_FADE_BOTTOM  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_IGNORE,
      KIND_START,
      KIND_NEWLINE,
      KIND_SPACE,
      KIND_QUAD
   } kind_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [7:0]         char_code;
      logic [6:0]         glyph_slot;
      logic [7:0]         glyph_u;
      logic [7:0]         glyph_v;
      logic [7:0]         glyph_width;
      logic [7:0]         glyph_height;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] left_x;
      logic signed [15:0] top_y;
      logic signed [15:0] right_x;
      logic signed [15:0] bottom_y;
      logic [8:0]         tex_left;
      logic [8:0]         tex_top;
      logic [8:0]         tex_right;
      logic [8:0]         tex_bottom;
      logic [23:0]        top_colour;
      logic [23:0]        bottom_colour;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] u;
      logic [7:0] v;
      logic [7:0] width;
      logic [7:0] height;
   } glyph_entry_type;

   typedef struct packed {
      logic        fade_enable;
      logic [23:0] plain_colour;
      logic [11:0] fade_top;
      logic [11:0] fade_bottom;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic        has_y;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
   } stage_type;

   // grey level d*20+255 clamped to 0..255
   function automatic logic [7:0] fade_grey(input logic signed [19:0] d);
      logic signed [25:0] lvl;
      lvl = (26'(d) <<< 4) + (26'(d) <<< 2) + 26'sd255;
      if (lvl < 26'sd0) begin
         fade_grey = 8'd0;
      end else if (lvl > 26'sd255) begin
         fade_grey = 8'd255;
      end else begin
         fade_grey = lvl[7:0];
      end
   endfunction

endpackage

>>> rtl/core/glq_ram.sv
// -----------------------------------------------------------------------------
// glq_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module glq_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 95,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/glq_csr.sv
// -----------------------------------------------------------------------------
// glq_csr
// Configuration registers: fade enable, plain colour and the two fade lines.
// -----------------------------------------------------------------------------
module glq_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [23:0]     csr_data,
   output glq_pkg::cfg_type cfg
);
   import glq_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;

   assign index = csr_index_type'(csr_index);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (index)
            CSR_FADE_ENABLE:  cfg_in.fade_enable  = csr_data[0];
            CSR_PLAIN_COLOUR: cfg_in.plain_colour = csr_data;
            CSR_FADE_TOP:     cfg_in.fade_top     = csr_data[11:0];
            CSR_FADE_BOTTOM:  cfg_in.fade_bottom  = csr_data[11:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fade_enable  <= 1'b0;
         cfg_ff.plain_colour <= PLAIN_COLOUR_RST;
         cfg_ff.fade_top     <= FADE_TOP_RST;
         cfg_ff.fade_bottom  <= FADE_BOTTOM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/glq_layout.sv
// -----------------------------------------------------------------------------
// glq_layout
// Cursor state, quad geometry, corner colours and the result register.
// -----------------------------------------------------------------------------
module glq_layout (
   input  logic                     clock,
   input  logic                     reset,
   input  glq_pkg::stage_type       stage,
   input  glq_pkg::glyph_entry_type entry,
   input  glq_pkg::cfg_type         cfg,
   output logic                     advance,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output glq_pkg::rsp_payload_type rsp_data
);
   import glq_pkg::*;

   logic [15:0]     cursor_x_ff, cursor_x_in;
   logic [15:0]     cursor_y_ff, cursor_y_in;
   logic [15:0]     line_x_ff, line_x_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic               emit, out_free;
   logic [15:0]        quad_right;
   logic signed [19:0] y_s, h_s, top_s, bot_s;
   logic [7:0]         top_grey, bot_grey;
   logic [23:0]        top_col, bot_col;

   assign emit     = stage.valid && (stage.kind == KIND_QUAD);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = stage.valid && (!emit || out_free);

   assign quad_right = cursor_x_ff + {8'd0, entry.width} + 16'd1;

   assign y_s   = {{4{cursor_y_ff[15]}}, cursor_y_ff};
   assign h_s   = {12'd0, entry.height};
   assign top_s = {8'd0, cfg.fade_top};
   assign bot_s = {8'd0, cfg.fade_bottom};

   always_comb begin
      top_grey = 8'd0;
      bot_grey = 8'd0;
      top_col  = cfg.plain_colour;
      bot_col  = cfg.plain_colour;
      if (cfg.fade_enable) begin
         priority if (y_s < top_s) begin
            top_grey = fade_grey(y_s - top_s);
            bot_grey = fade_grey(y_s + h_s - top_s);
            top_col  = {top_grey, top_grey, top_grey};
            bot_col  = {bot_grey, bot_grey, bot_grey};
         end else if (y_s + h_s > bot_s) begin
            top_grey = fade_grey(bot_s - y_s);
            bot_grey = fade_grey(bot_s - y_s - h_s);
            top_col  = {top_grey, top_grey, top_grey};
            bot_col  = {bot_grey, bot_grey, bot_grey};
         end else begin
            top_col = FULL_WHITE;
            bot_col = FULL_WHITE;
         end
      end
   end

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      line_x_in   = line_x_ff;
      if (advance) begin
         unique case (stage.kind)
            KIND_START: begin
               cursor_x_in = stage.origin_x;
               cursor_y_in = stage.origin_y;
               line_x_in   = stage.origin_x;
            end
            KIND_NEWLINE: begin
               cursor_x_in = line_x_ff;
               cursor_y_in = cursor_y_ff + LINE_GAP
                             + (stage.has_y ? {8'd0, entry.height} : 16'd0);
            end
            KIND_SPACE:  cursor_x_in = cursor_x_ff + SPACE_ADVANCE;
            KIND_QUAD:   cursor_x_in = quad_right;
            KIND_IGNORE: cursor_x_in = cursor_x_ff;
            default:     cursor_x_in = cursor_x_ff;
         endcase
      end
   end

   always_comb begin
      rsp_data_in.left_x        = cursor_x_ff;
      rsp_data_in.top_y         = cursor_y_ff;
      rsp_data_in.right_x       = quad_right;
      rsp_data_in.bottom_y      = cursor_y_ff + {8'd0, entry.height} + 16'd1;
      rsp_data_in.tex_left      = {1'b0, entry.u};
      rsp_data_in.tex_top       = {1'b0, entry.v};
      rsp_data_in.tex_right     = {1'b0, entry.u} + {1'b0, entry.width} + 9'd1;
      rsp_data_in.tex_bottom    = {1'b0, entry.v} + {1'b0, entry.height} + 9'd1;
      rsp_data_in.top_colour    = top_col;
      rsp_data_in.bottom_colour = bot_col;
      rsp_valid_in = (emit && advance) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= 16'd0;
         cursor_y_ff  <= 16'd0;
         line_x_ff    <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         line_x_ff    <= line_x_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/glyph_quad_layout_with_fade.sv
// -----------------------------------------------------------------------------
// glyph_quad_layout_with_fade
// Text layout engine: turns a stream of character requests into screen quads.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries requests: start (sets cursor and line origin), load (writes
//   one glyph entry) and character. rsp_* carries one quad per printable
//   character whose glyph slot is inside the table; other requests give none.
//   csr_* writes the fade enable, plain colour and fade lines; write only
//   while no request is in flight.
//   From request accept to rsp_valid, the glyph table read is registered
//   together with the request, then the cursor update and quad are computed
//   into the result register.
//   Throughput is one request per cycle unless a held quad stalls the stage,
//   since the cursor update feeds the next character directly.
//   Reset clears the cursor, line origin and pipeline valids and sets the
//   configuration to its defaults; the glyph table holds whatever it held and must be loaded before use.
//   When rsp_stall is high a pending quad holds; the stage behind it stalls
//   only if it holds another quad, so non-printing requests still drain.
// -----------------------------------------------------------------------------
module glyph_quad_layout_with_fade #(
   parameter int GLYPH_COUNT = glq_pkg::GLYPH_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  glq_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output glq_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [23:0]              csr_data
);
   import glq_pkg::*;

   localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

   stage_type       stage_ff, stage_in;
   cfg_type         cfg;
   glyph_entry_type entry;
   glyph_entry_type wr_entry;
   opcode_type      op;
   logic            accept, advance, wr_en;
   logic [7:0]      char_slot;
   logic [7:0]      rd_slot;
   logic            is_newline, slot_ok;

   assign op        = opcode_type'(req_data.opcode);
   assign req_stall = stage_ff.valid && !advance;
   assign accept    = req_valid && !req_stall;

   assign char_slot  = req_data.char_code - FIRST_CODE;
   assign is_newline = (req_data.char_code == CODE_LF) || (req_data.char_code == CODE_CR);
   assign slot_ok    = (req_data.char_code >= FIRST_CODE) && (req_data.char_code <= LAST_CODE)
                       && ({1'b0, char_slot} < 9'(GLYPH_COUNT));
   assign rd_slot    = is_newline ? CODE_Y_SLOT : char_slot;

   assign wr_en    = accept && (op == OP_LOAD) && ({2'b0, req_data.glyph_slot} < 9'(GLYPH_COUNT));
   assign wr_entry = '{u:      req_data.glyph_u,
                       v:      req_data.glyph_v,
                       width:  req_data.glyph_width,
                       height: req_data.glyph_height};

   always_comb begin
      stage_in          = stage_ff;
      stage_in.has_y    = ({1'b0, CODE_Y_SLOT} < 9'(GLYPH_COUNT));
      stage_in.origin_x = req_data.origin_x;
      stage_in.origin_y = req_data.origin_y;
      stage_in.kind     = KIND_IGNORE;
      if (accept) begin
         stage_in.valid = 1'b1;
         unique case (op)
            OP_START: stage_in.kind = KIND_START;
            OP_CHAR: begin
               priority if (is_newline) begin
                  stage_in.kind = KIND_NEWLINE;
               end else if (req_data.char_code == CODE_SPACE) begin
                  stage_in.kind = KIND_SPACE;
               end else if (slot_ok) begin
                  stage_in.kind = KIND_QUAD;
               end else begin
                  stage_in.kind = KIND_IGNORE;
               end
            end
            OP_LOAD:  stage_in.kind = KIND_IGNORE;
            OP_NONE:  stage_in.kind = KIND_IGNORE;
            default:  stage_in.kind = KIND_IGNORE;
         endcase
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end else begin
         stage_in = stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      if (accept) begin
         stage_ff.kind     <= stage_in.kind;
         stage_ff.has_y    <= stage_in.has_y;
         stage_ff.origin_x <= stage_in.origin_x;
         stage_ff.origin_y <= stage_in.origin_y;
      end
   end

   glq_ram #(
      .WIDTH ($bits(glyph_entry_type)),
      .DEPTH (GLYPH_COUNT)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_data.glyph_slot)),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (AW'(rd_slot)),
      .rd_data (entry)
   );

   glq_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   glq_layout u_layout (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage_ff),
      .entry     (entry),
      .cfg       (cfg),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/glq_checker.sv
// -----------------------------------------------------------------------------
// glq_checker
// Watches the request, quad and register ports of the glyph layout block. It
// keeps its own cursor, glyph metrics and fade settings, works out the quad
// each accepted request should give, and compares the quads in order.
// -----------------------------------------------------------------------------
module glq_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  glq_pkg::req_payload_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  glq_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [23:0]              csr_data,
   output int                       mismatch_count,
   output int                       quads_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import glq_pkg::*;

   localparam int FADE_STEP  = 20;
   localparam int FULL_LEVEL = 255;

   logic [15:0]     cursor_x;
   logic [15:0]     cursor_y;
   logic [15:0]     line_start_x;
   glyph_entry_type glyph_metrics [GLYPH_COUNT_DEF];
   cfg_type         cfg;
   rsp_payload_type expected_quads [$];

   initial begin
      mismatch_count = 0;
      quads_pending  = 0;
   end

   function automatic logic [23:0] grey_of(input int level);
      logic [7:0] g;
      if (level < 0) begin
         g = 8'd0;
      end else if (level > FULL_LEVEL) begin
         g = 8'd255;
      end else begin
         g = level[7:0];
      end
      return {g, g, g};
   endfunction

   // updates the cursor and table; returns 1 when a quad is due
   function automatic bit place_glyph(input req_payload_type r, output rsp_payload_type q);
      glyph_entry_type g;
      logic [7:0]      code;
      int              row;
      int              top_line;
      int              bottom_line;
      int              h;
      q = '0;
      case (opcode_type'(r.opcode))
         OP_START: begin
            cursor_x     = r.origin_x;
            line_start_x = r.origin_x;
            cursor_y     = r.origin_y;
            return 1'b0;
         end
         OP_LOAD: begin
            if (r.glyph_slot < GLYPH_COUNT_DEF) begin
               glyph_metrics[r.glyph_slot] = {r.glyph_u, r.glyph_v, r.glyph_width,
                                              r.glyph_height};
            end
            return 1'b0;
         end
         OP_CHAR: ;
         default: return 1'b0;
      endcase

      code = r.char_code;
      if (code == CODE_LF || code == CODE_CR) begin
         cursor_x = line_start_x;
         cursor_y = cursor_y + 16'(glyph_metrics[CODE_Y_SLOT].height) + LINE_GAP;
         return 1'b0;
      end
      if (code == CODE_SPACE) begin
         cursor_x = cursor_x + SPACE_ADVANCE;
         return 1'b0;
      end
      if (code < FIRST_CODE || code > LAST_CODE) begin
         return 1'b0;
      end

      g = glyph_metrics[code - FIRST_CODE];
      if (cfg.fade_enable) begin
         row         = int'($signed(cursor_y));
         top_line    = int'(cfg.fade_top);
         bottom_line = int'(cfg.fade_bottom);
         h           = int'(g.height);
         if (row < top_line) begin
            q.top_colour    = grey_of((row - top_line) * FADE_STEP + FULL_LEVEL);
            q.bottom_colour = grey_of((row + h - top_line) * FADE_STEP + FULL_LEVEL);
         end else if (row + h > bottom_line) begin
            q.top_colour    = grey_of((bottom_line - row) * FADE_STEP + FULL_LEVEL);
            q.bottom_colour = grey_of((bottom_line - row - h) * FADE_STEP + FULL_LEVEL);
         end else begin
            q.top_colour    = FULL_WHITE;
            q.bottom_colour = FULL_WHITE;
         end
      end else begin
         q.top_colour    = cfg.plain_colour;
         q.bottom_colour = cfg.plain_colour;
      end

      q.left_x     = cursor_x;
      q.top_y      = cursor_y;
      q.right_x    = cursor_x + 16'(g.width) + 16'd1;
      q.bottom_y   = cursor_y + 16'(g.height) + 16'd1;
      q.tex_left   = 9'(g.u);
      q.tex_top    = 9'(g.v);
      q.tex_right  = 9'(g.u) + 9'(g.width) + 9'd1;
      q.tex_bottom = 9'(g.v) + 9'(g.height) + 9'd1;
      cursor_x     = cursor_x + 16'(g.width) + 16'd1;
      return 1'b1;
   endfunction

   task automatic compare_field(input string field, input logic [23:0] want,
                                input logic [23:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type quad;
      if (reset) begin
         cursor_x     = '0;
         cursor_y     = '0;
         line_start_x = '0;
         cfg          = '{fade_enable: 1'b0, plain_colour: PLAIN_COLOUR_RST,
                          fade_top: FADE_TOP_RST, fade_bottom: FADE_BOTTOM_RST};
         expected_quads.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_FADE_ENABLE:  cfg.fade_enable  = csr_data[0];
               CSR_PLAIN_COLOUR: cfg.plain_colour = csr_data;
               CSR_FADE_TOP:     cfg.fade_top     = csr_data[11:0];
               CSR_FADE_BOTTOM:  cfg.fade_bottom  = csr_data[11:0];
               default: ;
            endcase
         end
         // a quad leaves only after its request has passed the stage and result registers, so compare first
         if (rsp_valid && !rsp_stall) begin
            if (expected_quads.size() == 0) begin
               $display("%0t: quad with no request pending, expected none got %p",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_quads.pop_front();
               compare_field("left_x", 24'(want.left_x), 24'(rsp_data.left_x));
               compare_field("top_y", 24'(want.top_y), 24'(rsp_data.top_y));
               compare_field("right_x", 24'(want.right_x), 24'(rsp_data.right_x));
               compare_field("bottom_y", 24'(want.bottom_y), 24'(rsp_data.bottom_y));
               compare_field("tex_left", 24'(want.tex_left), 24'(rsp_data.tex_left));
               compare_field("tex_top", 24'(want.tex_top), 24'(rsp_data.tex_top));
               compare_field("tex_right", 24'(want.tex_right), 24'(rsp_data.tex_right));
               compare_field("tex_bottom", 24'(want.tex_bottom), 24'(rsp_data.tex_bottom));
               compare_field("top_colour", want.top_colour, rsp_data.top_colour);
               compare_field("bottom_colour", want.bottom_colour, rsp_data.bottom_colour);
            end
         end
         if (req_valid && !req_stall) begin
            if (place_glyph(req_data, quad)) begin
               expected_quads.push_back(quad);
            end
         end
      end
      quads_pending <= expected_quads.size();
   end

endmodule

>>> tb/tb.sv
// -----------------------------------------------------------------------------
// tb
// Stimulus for the glyph quad layout block: loads the glyph table, runs
// directed passes over the field extremes, special characters and the fade
// window, then random text runs under several fade settings and back-pressure
// mixes. The checker beside the block predicts and compares every quad.
// -----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import glq_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int SEGMENTS     = 8;
   localparam int SEGMENT_SIZE = 150;
   localparam int SETTLE       = 4;
   localparam int DRAIN        = 10;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_write_en;
   logic [1:0]      csr_index;
   logic [23:0]     csr_data;
   int              mismatch_count;
   int              quads_pending;

   int cycle_count     = 0;
   int req_idle_pct    = 0;
   int rsp_idle_pct    = 0;
   int fade_top_now    = 280;
   int fade_bottom_now = 430;

   glyph_quad_layout_with_fade u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   glq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .quads_pending  (quads_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // unused fields carry random bits
   function automatic req_payload_type noisy_request();
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      return noise[$bits(req_payload_type)-1:0];
   endfunction

   function automatic req_payload_type start_request(input logic signed [15:0] x,
                                                     input logic signed [15:0] y);
      req_payload_type r;
      r          = noisy_request();
      r.opcode   = OP_START;
      r.origin_x = x;
      r.origin_y = y;
      return r;
   endfunction

   function automatic req_payload_type char_request(input logic [7:0] code);
      req_payload_type r;
      r           = noisy_request();
      r.opcode    = OP_CHAR;
      r.char_code = code;
      return r;
   endfunction

   function automatic req_payload_type load_request(input logic [6:0] slot,
                                                    input logic [7:0] u, input logic [7:0] v,
                                                    input logic [7:0] w, input logic [7:0] h);
      req_payload_type r;
      r              = noisy_request();
      r.opcode       = OP_LOAD;
      r.glyph_slot   = slot;
      r.glyph_u      = u;
      r.glyph_v      = v;
      r.glyph_width  = w;
      r.glyph_height = h;
      return r;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int              pick;
      int              base;
      logic [7:0]      code;
      pick = $urandom_range(99);
      if (pick < 8) begin
         r = start_request(16'($urandom), 16'($urandom));
         if ($urandom_range(1)) begin
            base       = $urandom_range(1) ? fade_top_now : fade_bottom_now;
            r.origin_y = 16'(base + int'($urandom_range(0, 600)) - 300);
         end
      end else if (pick < 70) begin
         r = char_request(8'($urandom_range(FIRST_CODE, LAST_CODE)));
      end else if (pick < 78) begin
         r = char_request($urandom_range(1) ? CODE_LF : CODE_CR);
      end else if (pick < 85) begin
         r = char_request(CODE_SPACE);
      end else if (pick < 93) begin
         r = load_request(7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
      end else if (pick < 97) begin
         if ($urandom_range(1)) begin
            code = 8'($urandom_range(128, 255));
         end else begin
            code = 8'($urandom_range(0, 31));
            if (code == CODE_LF || code == CODE_CR) begin
               code = code + 8'd1;
            end
         end
         r = char_request(code);
      end else begin
         r        = noisy_request();
         r.opcode = OP_NONE;
      end
      return r;
   endfunction

   task automatic send_request(input req_payload_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // hold requests until every quad is out and the pipeline has emptied
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (quads_pending != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_settings(input logic fade, input logic [23:0] plain,
                                 input logic [11:0] top_line,
                                 input logic [11:0] bottom_line);
      logic [23:0] noise;
      noise = 24'($urandom);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_FADE_ENABLE;
      csr_data     <= {noise[23:1], fade};
      @(posedge clock);
      csr_index <= CSR_PLAIN_COLOUR;
      csr_data  <= plain;
      @(posedge clock);
      csr_index <= CSR_FADE_TOP;
      csr_data  <= {noise[23:12], top_line};
      @(posedge clock);
      csr_index <= CSR_FADE_BOTTOM;
      csr_data  <= {noise[11:0], bottom_line};
      @(posedge clock);
      csr_write_en    <= 1'b0;
      fade_top_now    = int'(top_line);
      fade_bottom_now = int'(bottom_line);
   endtask

   task automatic apply_setting(input int n);
      logic [11:0] top_line;
      top_line = 12'($urandom_range(0, 500));
      case (n)
         0: write_settings(1'b0, 24'($urandom), 12'd280, 12'd430);
         1: write_settings(1'b1, 24'h000000, 12'd280, 12'd430);
         2: write_settings(1'b1, 24'hffffff, 12'd0, 12'd4095);
         3: write_settings(1'b1, 24'($urandom), 12'd4095, 12'd0);
         4: write_settings(1'b0, 24'h000000, 12'($urandom), 12'($urandom));
         5: write_settings(1'b0, 24'hffffff, 12'($urandom), 12'($urandom));
         6: write_settings(1'b1, 24'($urandom), 12'($urandom), 12'($urandom));
         default: write_settings(1'b1, 24'($urandom), top_line,
                                 top_line + 12'($urandom_range(0, 500)));
      endcase
   endtask

   initial begin
      req_valid    <= 1'b0;
      req_data     <= '0;
      rsp_stall    <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      reset        <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 13;
      rsp_idle_pct = 59;
      for (int slot = 0; slot < GLYPH_COUNT_DEF; slot++) begin
         send_request(load_request(7'(slot), 8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom)));
      end

      // directed: reset colours, special characters and wrap-around
      send_request(start_request(16'sd0, 16'sd0));
      send_request(char_request(FIRST_CODE));
      send_request(char_request(LAST_CODE));
      send_request(char_request(CODE_SPACE));
      send_request(char_request(CODE_LF));
      send_request(char_request(CODE_CR));
      send_request(char_request(8'd0));
      send_request(char_request(8'd128));
      send_request(char_request(8'd255));
      send_request(load_request(7'd127, 8'hff, 8'hff, 8'hff, 8'hff));
      send_request(load_request(7'd95, 8'hff, 8'hff, 8'hff, 8'hff));
      send_request(load_request(7'd0, 8'hff, 8'hff, 8'hff, 8'hff));
      send_request(start_request(16'sh7fff, 16'sh7fff));
      send_request(char_request(FIRST_CODE));
      send_request(load_request(7'd94, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(start_request(16'sh8000, 16'sh8000));
      send_request(char_request(LAST_CODE));

      // directed: fade above, inside and below the default window
      write_settings(1'b1, 24'hffffff, 12'd280, 12'd430);
      send_request(start_request(16'sd0, 16'sd0));
      send_request(char_request(FIRST_CODE));
      send_request(start_request(16'sd0, 16'sd275));
      send_request(char_request(8'd35));
      send_request(start_request(16'sd0, 16'sd300));
      send_request(load_request(7'd1, 8'd10, 8'd20, 8'd8, 8'd12));
      send_request(char_request(8'd34));
      send_request(start_request(16'sd0, 16'sd425));
      send_request(char_request(FIRST_CODE));

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 3) begin
            req_idle_pct = 13;
            rsp_idle_pct = 59;
         end else if (seg < 6) begin
            req_idle_pct = 59;
            rsp_idle_pct = 13;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         apply_setting(seg);
         repeat (SEGMENT_SIZE) send_request(random_request());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (quads_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/glq_pkg.sv
rtl/core/glq_ram.sv
rtl/core/glq_csr.sv
rtl/core/glq_layout.sv
rtl/core/glyph_quad_layout_with_fade.sv
tb/glq_checker.sv
tb/tb.sv
